// File: design/fplw_pkg.sv
// ----------------------------------------------------------------------------
// fplw_pkg
// Shared types, codes and constants of the four-level page walker.
// ----------------------------------------------------------------------------
package fplw_pkg;

    localparam int WORD_BITS            = 64;
    localparam int STORE_INDEX_BITS_DEF = 16;
    localparam int TABLE_INDEX_BITS     = 9;
    localparam int PAGE_OFFSET_BITS     = 12;
    localparam int ENTRY_SHIFT          = 3;

    // Index positions of the four table levels
    localparam int LEVEL0_SHIFT = 39;
    localparam int LEVEL1_SHIFT = 30;
    localparam int LEVEL2_SHIFT = 21;
    localparam int LEVEL3_SHIFT = 12;

    localparam logic [1:0] LEVEL_FIRST = 2'd0;
    localparam logic [1:0] LEVEL_LAST  = 2'd3;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_XLATE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
    localparam logic [1:0] STATUS_ADDR_ERR    = 2'd2;

    // Control of one word store access
    typedef struct packed {
        logic en;      // access this cycle
        logic we;      // write, else read
        logic valid;   // valid mark to write
    } store_ctl_t;

    // Pick the table index of one level out of a virtual address
    function automatic logic [TABLE_INDEX_BITS-1:0] table_index(
        input logic [WORD_BITS-1:0] va,
        input logic [1:0]           level
    );
        logic [TABLE_INDEX_BITS-1:0] idx;
        begin
            unique case (level)
                2'd0:    idx = va[LEVEL0_SHIFT +: TABLE_INDEX_BITS];
                2'd1:    idx = va[LEVEL1_SHIFT +: TABLE_INDEX_BITS];
                2'd2:    idx = va[LEVEL2_SHIFT +: TABLE_INDEX_BITS];
                default: idx = va[LEVEL3_SHIFT +: TABLE_INDEX_BITS];
            endcase
            return idx;
        end
    endfunction

endpackage

// File: design/four_level_page_walker_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_walker_unit
// Word store with read, write and four-level page table translation.
// Write, unused mode or bad start address: answered from the idle state;
// read: one store read; translation: one store read per level through the
// registered read port. Writes leave the unit idle; reads and translations
// hold busy high until their result is out. After reset busy stays high while
// the valid marks are cleared; configuration writes are taken meanwhile.
// Results are strobed by done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module four_level_page_walker_unit
    import fplw_pkg::*;
#(
    parameter int STORE_INDEX_BITS = STORE_INDEX_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Item transfer
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [WORD_BITS-1:0] address,
    input  logic [WORD_BITS-1:0] write_value,
    // Result transfer
    output logic                 done,
    output logic [1:0]           status,
    output logic [WORD_BITS-1:0] data,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [WORD_BITS-1:0] pwdata,
    output logic [WORD_BITS-1:0] prdata,
    output logic                 pready
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_WALK  = 2'd3;

    localparam int HIGH_LSB = STORE_INDEX_BITS + ENTRY_SHIFT;

    logic [1:0]                  state_reg, state_next;
    logic [STORE_INDEX_BITS-1:0] clr_reg, clr_next;
    logic [1:0]                  level_reg, level_next;
    logic [WORD_BITS-1:0]        va_reg, va_next;
    logic [WORD_BITS-1:0]        root_reg;
    logic                        done_reg, done_next;
    logic [1:0]                  status_reg, status_next;
    logic [WORD_BITS-1:0]        data_reg, data_next;

    store_ctl_t                  st_ctl;
    logic [STORE_INDEX_BITS-1:0] st_index;
    logic                        q_valid;
    logic [WORD_BITS-1:0]        q_data;

    logic [WORD_BITS-1:0]        entry;
    logic [WORD_BITS-1:0]        page_base;
    logic [WORD_BITS-1:0]        ea_base;
    logic [WORD_BITS-1:0]        ea_va;
    logic [1:0]                  ea_level;
    logic [WORD_BITS-1:0]        ea;

    // Usable store address: word aligned and inside the store
    function automatic logic addr_ok(input logic [WORD_BITS-1:0] a);
        begin
            return (a[ENTRY_SHIFT-1:0] == '0) && (a[WORD_BITS-1:HIGH_LSB] == '0);
        end
    endfunction

    fplw_word_store #(
        .INDEX_BITS (STORE_INDEX_BITS)
    ) u_store (
        .clk     (clk),
        .ctl     (st_ctl),
        .index   (st_index),
        .wdata   (write_value),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    // Configuration register: one 64-bit register; paddr is not decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            root_reg <= pwdata;
        end
    end

    assign prdata = root_reg;
    assign pready = 1'b1;

    // Entry seen by the walk, next table base and next entry address
    assign entry     = q_valid ? q_data : '0;
    assign page_base = {entry[WORD_BITS-1:PAGE_OFFSET_BITS], {PAGE_OFFSET_BITS{1'b0}}};
    assign ea_base   = (state_reg == S_IDLE) ? root_reg : page_base;
    assign ea_va     = (state_reg == S_IDLE) ? address : va_reg;
    assign ea_level  = (state_reg == S_IDLE) ? LEVEL_FIRST : 2'(level_reg + 2'd1);
    assign ea        = ea_base + {{(WORD_BITS - TABLE_INDEX_BITS - ENTRY_SHIFT){1'b0}},
                                  table_index(ea_va, ea_level), {ENTRY_SHIFT{1'b0}}};

    // Sequencer: clear pass, accept, store access, walk levels
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        level_next  = level_reg;
        va_next     = va_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        st_ctl      = '0;
        st_index    = address[HIGH_LSB-1:ENTRY_SHIFT];

        unique case (state_reg)
            S_CLEAR:
            begin
                st_ctl.en = 1'b1;
                st_ctl.we = 1'b1;
                st_index  = clr_reg;
                clr_next  = clr_reg + {{(STORE_INDEX_BITS-1){1'b0}}, 1'b1};
                if (clr_reg == {STORE_INDEX_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    va_next     = address;
                    status_next = STATUS_OK;
                    data_next   = '0;
                    unique case (mode)
                        MODE_WRITE:
                        begin
                            done_next = 1'b1;
                            if (addr_ok(address))
                            begin
                                st_ctl.en    = 1'b1;
                                st_ctl.we    = 1'b1;
                                st_ctl.valid = 1'b1;
                            end
                            else
                            begin
                                status_next = STATUS_ADDR_ERR;
                            end
                        end
                        MODE_READ:
                        begin
                            if (addr_ok(address))
                            begin
                                st_ctl.en  = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_ADDR_ERR;
                            end
                        end
                        MODE_XLATE:
                        begin
                            st_index = ea[HIGH_LSB-1:ENTRY_SHIFT];
                            if (addr_ok(ea))
                            begin
                                st_ctl.en  = 1'b1;
                                level_next = LEVEL_FIRST;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_ADDR_ERR;
                            end
                        end
                        MODE_NONE:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next   = 1'b1;
                status_next = STATUS_OK;
                data_next   = entry;
                state_next  = S_IDLE;
            end
            S_WALK:
            begin
                st_index = ea[HIGH_LSB-1:ENTRY_SHIFT];
                priority if (!entry[0])
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NOT_PRESENT;
                    data_next   = '0;
                    state_next  = S_IDLE;
                end
                else if (level_reg == LEVEL_LAST)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    data_next   = page_base
                                + {{(WORD_BITS - PAGE_OFFSET_BITS){1'b0}},
                                   va_reg[PAGE_OFFSET_BITS-1:0]};
                    state_next  = S_IDLE;
                end
                else if (addr_ok(ea))
                begin
                    st_ctl.en  = 1'b1;
                    level_next = 2'(level_reg + 2'd1);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_ADDR_ERR;
                    data_next   = '0;
                    state_next  = S_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            level_reg <= LEVEL_FIRST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
    end

    // Hold the walked address and the result payload
    always_ff @(posedge clk)
    begin
        va_reg     <= va_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;

endmodule

// File: design/fplw_word_store.sv
// ----------------------------------------------------------------------------
// fplw_word_store
// Single-port word store: 64-bit words with a valid mark, registered read.
// ----------------------------------------------------------------------------
module fplw_word_store
    import fplw_pkg::*;
#(
    parameter int INDEX_BITS = STORE_INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  store_ctl_t            ctl,
    input  logic [INDEX_BITS-1:0] index,
    input  logic [WORD_BITS-1:0]  wdata,
    output logic                  q_valid,
    output logic [WORD_BITS-1:0]  q_data
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [WORD_BITS:0] mem [DEPTH];
    logic [WORD_BITS:0] q_reg;

    // Write the word together with its valid mark
    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.we)
        begin
            mem[index] <= {ctl.valid, wdata};
        end
    end

    // Registered read: q_reg holds the last word read
    always_ff @(posedge clk)
    begin
        if (ctl.en && !ctl.we)
        begin
            q_reg <= mem[index];
        end
    end

    assign q_valid = q_reg[WORD_BITS];
    assign q_data  = q_reg[WORD_BITS-1:0];

endmodule
